@@ sv/stereo_mixer_volume_fade_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo mixer volume fader
// Property wrappers on clk with a synchronous active-high rst.
// ----------------------------------------------------------------------------
`ifndef STEREO_MIXER_VOLUME_FADE_ASSERT_SVH
`define STEREO_MIXER_VOLUME_FADE_ASSERT_SVH

// Same-cycle implication.
`define SMVF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/smvf_pkg.sv @@
// ----------------------------------------------------------------------------
// smvf_pkg
// Shared widths, constants and types of the stereo mixer volume fader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smvf_pkg;

  localparam int LEVEL_W    = 19;
  localparam int OUT_W      = 7;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = $clog2(NUM_CH);
  localparam int ITER_W     = $clog2(LEVEL_W);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = CH_W + 2;

  localparam int FADE_LIMIT_DEF    = 4095;
  localparam int FRACTION_BITS_DEF = 12;

  localparam logic [LEVEL_W-1:0] FULL_RESET = 19'h7F000;

  localparam logic FUNC_TICK = 1'b1;

  // Mixer path order, shared by the register map and the level array.
  localparam logic [CH_W-1:0] CH_LL = 2'd0;
  localparam logic [CH_W-1:0] CH_LR = 2'd1;
  localparam logic [CH_W-1:0] CH_RR = 2'd2;
  localparam logic [CH_W-1:0] CH_RL = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            load_count;
    logic            mul;
    logic            div_step;
    logic            write_back;
    logic            last_ch;
    logic            emit;
    logic [CH_W-1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_pos;
  } dp_status_t;

  typedef logic [NUM_CH-1:0][LEVEL_W-1:0] level_array_t;
  typedef logic [NUM_CH-1:0][OUT_W-1:0]   out_array_t;

endpackage

@@ sv/smvf_regs.sv @@
// ----------------------------------------------------------------------------
// smvf_regs
// APB-style register bank holding the four full levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smvf_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smvf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [smvf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [smvf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output smvf_pkg::level_array_t              full
);

  logic [smvf_pkg::CH_W-1:0] idx;
  logic                      wr_en;

  assign idx    = paddr[smvf_pkg::APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = smvf_pkg::APB_DATA_W'(full[idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < smvf_pkg::NUM_CH; i++) begin
        full[i] <= smvf_pkg::FULL_RESET;
      end
    end else if (wr_en) begin
      full[idx] <= pwdata[smvf_pkg::LEVEL_W-1:0];
    end
  end

endmodule

@@ sv/smvf_ctrl.sv @@
// ----------------------------------------------------------------------------
// smvf_ctrl
// Sequencer that walks the four paths through the shared multiply-divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smvf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 func,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  smvf_pkg::dp_status_t status,
  output smvf_pkg::dp_cmd_t    cmd
);

  smvf_pkg::state_t            state;
  smvf_pkg::state_t            state_next;
  logic [smvf_pkg::CH_W-1:0]   ch;
  logic [smvf_pkg::ITER_W-1:0] iter;
  logic                        iter_last;
  logic                        out_free;

  assign iter_last = (iter == smvf_pkg::ITER_W'(smvf_pkg::LEVEL_W - 1));
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      smvf_pkg::ST_IDLE: begin
        if (in_valid && (func == smvf_pkg::FUNC_TICK)) begin
          state_next = status.count_zero ? smvf_pkg::ST_DONE : smvf_pkg::ST_MUL;
        end
      end
      smvf_pkg::ST_MUL: begin
        state_next = smvf_pkg::ST_DIV;
      end
      smvf_pkg::ST_DIV: begin
        if (iter_last) begin
          state_next = smvf_pkg::ST_WB;
        end
      end
      smvf_pkg::ST_WB: begin
        state_next = cmd.last_ch ? smvf_pkg::ST_DONE : smvf_pkg::ST_MUL;
      end
      smvf_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = smvf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smvf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state == smvf_pkg::ST_IDLE);
    cmd.load_count = (state == smvf_pkg::ST_IDLE) && in_valid &&
                     (func != smvf_pkg::FUNC_TICK);
    cmd.mul        = (state == smvf_pkg::ST_MUL);
    cmd.div_step   = (state == smvf_pkg::ST_DIV);
    cmd.write_back = (state == smvf_pkg::ST_WB);
    cmd.last_ch    = (ch == smvf_pkg::CH_W'(smvf_pkg::NUM_CH - 1));
    cmd.emit       = (state == smvf_pkg::ST_DONE) && out_free;
    cmd.ch         = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smvf_pkg::ST_IDLE;
      ch        <= '0;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == smvf_pkg::ST_IDLE) begin
        ch <= '0;
      end else if (cmd.write_back) begin
        ch <= ch + 1'b1;
      end
      if (cmd.mul) begin
        iter <= '0;
      end else if (cmd.div_step) begin
        iter <= iter + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/smvf_dp.sv @@
// ----------------------------------------------------------------------------
// smvf_dp
// Fade counter, live levels, shared multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smvf_dp #(
  parameter int FADE_LIMIT    = smvf_pkg::FADE_LIMIT_DEF,
  parameter int FRACTION_BITS = smvf_pkg::FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  smvf_pkg::dp_cmd_t      cmd,
  input  logic signed [31:0]     fade_frames,
  input  smvf_pkg::level_array_t full,
  output smvf_pkg::dp_status_t   status,
  output smvf_pkg::out_array_t   levels
);

  localparam int K_W     = $clog2(FADE_LIMIT + 1);
  localparam int COUNT_W = K_W + 1;
  localparam int PROD_W  = smvf_pkg::LEVEL_W + K_W;
  localparam int LW      = smvf_pkg::LEVEL_W;
  localparam logic signed [31:0] LIM_POS = 32'(FADE_LIMIT);
  localparam logic signed [31:0] LIM_NEG = -32'(FADE_LIMIT);

  logic signed [COUNT_W-1:0] count;
  smvf_pkg::level_array_t    live;
  logic [K_W-1:0]            rem;
  logic [LW-1:0]             dvd;
  logic                      neg;

  logic signed [31:0]        clamped;
  logic [COUNT_W-1:0]        k_abs;
  logic [K_W-1:0]            k;
  logic [K_W-1:0]            km1;
  logic [LW-1:0]             cur_live;
  logic [LW-1:0]             cur_full;
  logic [LW:0]               gap;
  logic [LW:0]               gap_abs;
  logic [LW-1:0]             mag;
  logic [PROD_W-1:0]         prod;
  logic [K_W:0]              trial;
  logic [K_W:0]              diff;
  logic                      ge;
  logic [LW:0]               sum;
  logic [LW:0]               sub;
  logic [LW-1:0]             new_level;
  smvf_pkg::level_array_t    shifted;

  assign status.count_zero = (count == '0);
  assign status.count_pos  = !count[COUNT_W-1] && (count != '0);

  always_comb begin
    if (fade_frames > LIM_POS) begin
      clamped = LIM_POS;
    end else if (fade_frames < LIM_NEG) begin
      clamped = LIM_NEG;
    end else begin
      clamped = fade_frames;
    end
  end

  assign k_abs    = count[COUNT_W-1] ? COUNT_W'(-count) : COUNT_W'(count);
  assign k        = k_abs[K_W-1:0];
  assign km1      = k - 1'b1;
  assign cur_live = live[cmd.ch];
  assign cur_full = full[cmd.ch];

  // Fade-in works on the signed gap to the full level.
  assign gap      = {1'b0, cur_full} - {1'b0, cur_live};
  assign gap_abs  = gap[LW] ? (~gap + 1'b1) : gap;
  assign mag      = status.count_pos ? cur_live : gap_abs[LW-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(km1);

  // One quotient bit per step; the remainder always stays below k.
  assign trial = {rem, dvd[LW-1]};
  assign diff  = trial - {1'b0, k};
  assign ge    = (trial >= {1'b0, k});

  assign sum = {1'b0, cur_full} + {1'b0, dvd};
  assign sub = {1'b0, cur_full} - {1'b0, dvd};

  always_comb begin
    if (status.count_pos) begin
      new_level = dvd;
    end else if (neg) begin
      new_level = sum[LW-1:0];
    end else begin
      new_level = sub[LW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < smvf_pkg::NUM_CH; i++) begin
      shifted[i] = live[i] >> FRACTION_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      live  <= '0;
    end else begin
      if (cmd.load_count) begin
        count <= clamped[COUNT_W-1:0];
      end else if (cmd.write_back && cmd.last_ch) begin
        count <= status.count_pos ? (count - COUNT_W'(1)) : (count + COUNT_W'(1));
      end
      if (cmd.write_back) begin
        live[cmd.ch] <= new_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem <= prod[PROD_W-1:LW];
      dvd <= prod[LW-1:0];
      neg <= gap[LW];
    end else if (cmd.div_step) begin
      rem <= ge ? diff[K_W-1:0] : trial[K_W-1:0];
      dvd <= {dvd[LW-2:0], ge};
    end
    if (cmd.emit) begin
      for (int i = 0; i < smvf_pkg::NUM_CH; i++) begin
        levels[i] <= shifted[i][smvf_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

@@ sv/stereo_mixer_volume_fade.sv @@
// ----------------------------------------------------------------------------
// stereo_mixer_volume_fade - four-path stereo cross-mixer volume fader
// Start request: loads the fade count, gives no result, and leaves the block idle and ready.
// Tick request: one result each, with the divider skipped for a zero count; one divider bit per cycle.
// Reset (synchronous, rst high): count and live levels zero, full levels 0x7F000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_mixer_volume_fade #(
  parameter int FADE_LIMIT    = smvf_pkg::FADE_LIMIT_DEF,
  parameter int FRACTION_BITS = smvf_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smvf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [smvf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [smvf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // Input requests.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic signed [31:0]              fade_frames,
  // Result requests.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [smvf_pkg::OUT_W-1:0]      level_ll,
  output logic [smvf_pkg::OUT_W-1:0]      level_lr,
  output logic [smvf_pkg::OUT_W-1:0]      level_rr,
  output logic [smvf_pkg::OUT_W-1:0]      level_rl
);

  // The sequencer takes a request only in its idle state. A start request
  // loads the clamped fade count, and the sequencer stays idle. A tick with a
  // nonzero count runs each of the four paths through the same hardware:
  // a multiply by (k-1), restoring division by k over all 19 level bits and
  // a write-back. A finished result sits in the output register, so the
  // next request is taken while that result waits; only a second tick
  // waits in the done state for the register to drain.

  smvf_pkg::dp_cmd_t      cmd;
  smvf_pkg::dp_status_t   status;
  smvf_pkg::level_array_t full;
  smvf_pkg::out_array_t   levels;

  smvf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .full    (full)
  );

  smvf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  smvf_dp #(
    .FADE_LIMIT    (FADE_LIMIT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .fade_frames (fade_frames),
    .full        (full),
    .status      (status),
    .levels      (levels)
  );

  // The level array follows the register map order of the mixer paths.
  assign level_ll = levels[smvf_pkg::CH_LL];
  assign level_lr = levels[smvf_pkg::CH_LR];
  assign level_rr = levels[smvf_pkg::CH_RR];
  assign level_rl = levels[smvf_pkg::CH_RL];

endmodule

@@ sv/smvf_checker.sv @@
// ----------------------------------------------------------------------------
// smvf_checker
// Port-level checks of the fader, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_mixer_volume_fade_assert.svh"

module smvf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       func,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [smvf_pkg::OUT_W-1:0] level_ll,
  input logic [smvf_pkg::OUT_W-1:0] level_lr,
  input logic [smvf_pkg::OUT_W-1:0] level_rr,
  input logic [smvf_pkg::OUT_W-1:0] level_rl
);

  logic                                       out_stall;
  logic                                       tick_req;
  logic [smvf_pkg::NUM_CH*smvf_pkg::OUT_W-1:0] levels_all;

  assign out_stall  = out_valid && !out_ready;
  assign tick_req   = in_valid && in_ready && (func == smvf_pkg::FUNC_TICK);
  assign levels_all = {level_ll, level_lr, level_rr, level_rl};

  // A stalled result stays offered.
  `SMVF_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped")

  // A stalled result keeps its levels.
  `SMVF_ASSERT_NEXT(a_out_stable, out_stall, $stable(levels_all), "result changed while stalled")

  // A tick leaves the block busy in the next cycle.
  `SMVF_ASSERT_NEXT(a_tick_busy, tick_req, !in_ready, "tick did not occupy the block")

  // A new result is only produced out of the busy state.
  `SMVF_ASSERT_IMPL(a_emit_busy, $rose(out_valid), !$past(in_ready), "result without a tick")

endmodule

bind stereo_mixer_volume_fade smvf_checker u_smvf_checker (.*);

@@ tb/stereo_mixer_volume_fade_tb.sv @@
// ----------------------------------------------------------------------------
// stereo_mixer_volume_fade_tb - self-checking bench for the volume fader
// Drives start and tick requests with random back-pressure on both sides,
// predicts every level byte in a local fader model and checks each result
// in order. Full levels are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_mixer_volume_fade_tb;
  import smvf_pkg::*;

  // A start request is any request that is not a tick.
  localparam logic FUNC_START = ~FUNC_TICK;

  // Cycles with no accepted request before the run is declared hung. This is
  // many times the slowest tick plus a sender gap and a receiver stall.
  localparam int STALL_LIMIT = 4000;

  // Full levels at the top of the legal range.
  localparam logic [31:0] FULL_TOP = 32'd520192;

  // Tracks the fader state and holds the level bytes that ticks have earned.
  class fader_model;
    logic [LEVEL_W-1:0] full_level [NUM_CH];
    logic [LEVEL_W-1:0] live_level [NUM_CH];
    int                 fade_count;
    out_array_t         level_queue [$];
    int                 mismatch_count;

    function new();
      for (int i = 0; i < NUM_CH; i++) begin
        full_level[i] = FULL_RESET;
        live_level[i] = '0;
      end
      fade_count     = 0;
      mismatch_count = 0;
    endfunction

    function void set_full_level(logic [CH_W-1:0] path, logic [31:0] value);
      full_level[path] = value[LEVEL_W-1:0];
    endfunction

    // Applies one accepted request and queues the levels a tick produces.
    function void note_request(logic f, logic signed [31:0] frames);
      longint     k;
      longint     lv;
      longint     fl;
      longint     gap;
      longint     scaled;
      out_array_t levels;
      if (f != FUNC_TICK) begin
        if (frames > FADE_LIMIT_DEF) fade_count = FADE_LIMIT_DEF;
        else if (frames < -FADE_LIMIT_DEF) fade_count = -FADE_LIMIT_DEF;
        else fade_count = frames;
        return;
      end
      if (fade_count > 0) begin
        k = fade_count;
        for (int i = 0; i < NUM_CH; i++) begin
          lv = live_level[i];
          live_level[i] = LEVEL_W'((lv * (k - 1)) / k);
        end
        fade_count--;
      end else if (fade_count < 0) begin
        k = -fade_count;
        for (int i = 0; i < NUM_CH; i++) begin
          lv     = live_level[i];
          fl     = full_level[i];
          gap    = fl - lv;
          scaled = (((gap < 0) ? -gap : gap) * (k - 1)) / k;
          live_level[i] = LEVEL_W'((gap < 0) ? fl + scaled : fl - scaled);
        end
        fade_count++;
      end
      for (int i = 0; i < NUM_CH; i++)
        levels[i] = OUT_W'(live_level[i] >> FRACTION_BITS_DEF);
      level_queue.push_back(levels);
    endfunction

    function void flag(string what, out_array_t want, out_array_t seen);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s: expected ll=%0d lr=%0d rr=%0d rl=%0d, got ll=%0d lr=%0d rr=%0d rl=%0d",
                 what, want[CH_LL], want[CH_LR], want[CH_RR], want[CH_RL],
                 seen[CH_LL], seen[CH_LR], seen[CH_RR], seen[CH_RL]);
    endfunction

    function void check_levels(logic [OUT_W-1:0] ll, logic [OUT_W-1:0] lr,
                               logic [OUT_W-1:0] rr, logic [OUT_W-1:0] rl);
      out_array_t seen;
      out_array_t want;
      bit         bad;
      seen[CH_LL] = ll;
      seen[CH_LR] = lr;
      seen[CH_RR] = rr;
      seen[CH_RL] = rl;
      if (level_queue.size() == 0) begin
        flag("level result with no tick pending", '0, seen);
        return;
      end
      want = level_queue.pop_front();
      bad  = 1'b0;
      for (int i = 0; i < NUM_CH; i++)
        if (seen[i] !== want[i]) bad = 1'b1;
      if (bad) flag("level mismatch", want, seen);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  func        = FUNC_TICK;
  logic signed [31:0]    fade_frames = '0;

  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [OUT_W-1:0]      level_ll;
  logic [OUT_W-1:0]      level_lr;
  logic [OUT_W-1:0]      level_rr;
  logic [OUT_W-1:0]      level_rl;

  // Idle rates in percent, changed from phase to phase by the main sequence.
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 58;
  int          stall_cycles  = 0;

  fader_model model;

  stereo_mixer_volume_fade dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .fade_frames (fade_frames),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_ll    (level_ll),
    .level_lr    (level_lr),
    .level_rr    (level_rr),
    .level_rl    (level_rl)
  );

  always #1 clk = ~clk;

  // The receiver decides afresh every cycle whether it can take a result.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result is checked against the oldest pending tick. The
  // values are read before this edge's updates land, so no race is possible.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      model.check_levels(level_ll, level_lr, level_rr, level_rl);
  end

  // The watchdog restarts on every accepted request on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("stereo_mixer_volume_fade_tb NOT OK");
        $finish;
      end
    end
  end

  // One register write: a setup cycle, then an access cycle that completes
  // on pready. The trailing cycle keeps psel from being lowered and raised
  // again within one time step when writes follow one another.
  task automatic write_full_level(logic [CH_W-1:0] path, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({path, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.set_full_level(path, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_full_levels(logic [31:0] ll, logic [31:0] lr,
                                  logic [31:0] rr, logic [31:0] rl);
    write_full_level(CH_LL, ll);
    write_full_level(CH_LR, lr);
    write_full_level(CH_RR, rr);
    write_full_level(CH_RL, rl);
  endtask

  // Sends one request. Valid is only lowered when the sender idles, so a
  // request that follows directly keeps valid high with a new payload.
  task automatic send_request(logic f, logic signed [31:0] frames);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    fade_frames <= frames;
    do @(posedge clk); while (!in_ready);
    model.note_request(f, frames);
  endtask

  // The frame count on a tick is ignored, so it always carries random bits.
  task automatic send_tick();
    send_request(FUNC_TICK, $urandom);
  endtask

  // Drops valid and waits until every earned result has come back. A start
  // request has no result, so the task waits on past the drain to let one finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (model.level_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly complete fades of random length and direction, so the levels
  // really climb to their targets and decay back. The rest are fades cut
  // short, stray requests with random payloads, and clamped start counts.
  task automatic run_random(int count);
    int                 sent;
    int                 pick;
    int                 span;
    int                 ticks;
    logic signed [31:0] frames;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        span   = $urandom_range(20, 1);
        frames = (pick < 40 || (pick >= 60 && pick < 68)) ? -span : span;
        ticks  = (pick < 60) ? span + $urandom_range(2) : $urandom_range(span - 1);
      end else if (pick < 90) begin
        frames = $urandom;
        ticks  = -1;
      end else begin
        case ($urandom_range(5))
          0: frames = FADE_LIMIT_DEF;
          1: frames = -FADE_LIMIT_DEF;
          2: frames = FADE_LIMIT_DEF + 1;
          3: frames = 32'sh7FFF_FFFF;
          4: frames = 32'sh8000_0000;
          default: frames = $urandom;
        endcase
        ticks = $urandom_range(3);
      end
      if (ticks < 0) begin
        // A lone request of either kind with a fully random count.
        send_request($urandom_range(1) ? FUNC_TICK : FUNC_START, frames);
        sent++;
      end else begin
        send_request(FUNC_START, frames);
        repeat (ticks) send_tick();
        sent += 1 + ticks;
      end
    end
  endtask

  initial begin
    model = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The all-ones write checks that only the low 19 bits are kept.
    load_full_levels(32'hFFFF_FFFF, FULL_TOP, 32'd0, $urandom_range(FULL_TOP));

    // Directed part. A tick with a zero count holds the levels; start counts
    // beyond the limit in either direction are clamped.
    send_tick();
    send_request(FUNC_START, 32'sh7FFF_FFFF);
    send_request(FUNC_START, 32'sh8000_0000);
    send_request(FUNC_START, FADE_LIMIT_DEF + 1);
    send_request(FUNC_START, -FADE_LIMIT_DEF - 1);
    send_tick();
    // A short fade-in lands exactly on the full levels at its last tick.
    send_request(FUNC_START, -3);
    repeat (3) send_tick();
    send_tick();
    // The slowest fade-out step, then a fade-out that reaches zero.
    send_request(FUNC_START, FADE_LIMIT_DEF);
    send_tick();
    send_request(FUNC_START, 2);
    repeat (2) send_tick();
    send_request(FUNC_START, -1);
    send_tick();
    send_request(FUNC_START, 0);
    send_tick();

    // Lower the ll, lr and (unless it drew zero) rl targets below the live levels, so
    // the next fade-in has to bring them down rather than up.
    settle();
    load_full_levels(32'h0000_1000, 32'd0, FULL_TOP, 32'd0);
    send_request(FUNC_START, -3);
    repeat (3) send_tick();

    // First random phase: sender idles 37 percent, receiver 58 percent.
    settle();
    load_full_levels($urandom_range(FULL_TOP), $urandom_range(FULL_TOP),
                     $urandom_range(FULL_TOP), $urandom_range(FULL_TOP));
    run_random(310);

    // Second phase: idle rates swapped, targets at the ends of the range.
    settle();
    send_idle_pct = 58;
    recv_idle_pct = 37;
    load_full_levels($urandom_range(1) ? FULL_TOP : 32'd0,
                     $urandom_range(1) ? FULL_TOP : 32'd0,
                     $urandom_range(1) ? FULL_TOP : 32'd0,
                     $urandom_range(1) ? FULL_TOP : 32'd0);
    run_random(310);

    // Last phase: no idling at all, raw 32-bit register values.
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_full_levels($urandom, $urandom, $urandom, $urandom);
    run_random(310);

    // Drain, then give a stray result time to show up before the verdict.
    in_valid <= 1'b0;
    while (model.level_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (model.mismatch_count == 0) begin
      $display("stereo_mixer_volume_fade_tb OK");
    end else begin
      $display("stereo_mixer_volume_fade_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/smvf_pkg.sv
sv/smvf_regs.sv
sv/smvf_ctrl.sv
sv/smvf_dp.sv
sv/stereo_mixer_volume_fade.sv
sv/smvf_checker.sv
tb/stereo_mixer_volume_fade_tb.sv
